@@ rtl/core/mpq_pkg.sv @@
package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

endpackage

@@ rtl/core/mpq_if.sv @@
interface mpq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [mpq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mpq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mpq_pkg::DATA_W-1:0]     result_value;
    logic [1:0]                            status;
    logic [mpq_pkg::OUT_CNT_W-1:0]         entry_count;
    logic                                  is_empty;

    modport source (output valid, output result_value, output status,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input result_value, input status,
                    input entry_count, input is_empty, output ready);
endinterface

@@ rtl/core/mpq_ctrl.sv @@
module mpq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          rsp_ready,
    output logic          req_ready,
    output logic          rsp_valid,
    output mpq_pkg::ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        ctl.load       = (state_reg == S_IDLE) && req_valid;
        ctl.exec       = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // The operation retires only once the output register is free or being drained.
                if (ctl.exec)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

@@ rtl/core/mpq_datapath.sv @@
module mpq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpq_pkg::ctl_t                       ctl,
    input  logic                                cmd,
    input  logic signed [mpq_pkg::DATA_W-1:0]   value,
    output logic signed [mpq_pkg::DATA_W-1:0]   result_value,
    output logic [1:0]                          status,
    output logic [mpq_pkg::OUT_CNT_W-1:0]       entry_count,
    output logic                                is_empty
);

    localparam int CAP = mpq_pkg::CAPACITY;
    localparam int DW  = mpq_pkg::DATA_W;
    localparam int CW  = mpq_pkg::CNT_W;
    localparam int OW  = mpq_pkg::OUT_CNT_W;

    // One cell per slot; cells holding a value form a prefix marked by valid_reg.
    logic signed [DW-1:0] entries_reg [CAP];
    logic signed [DW-1:0] entries_next [CAP];
    logic [CAP-1:0]       valid_reg;
    logic [CAP-1:0]       valid_next;
    logic [CAP-1:0]       keep;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    logic                 op_cmd_reg;
    logic signed [DW-1:0] op_value_reg;

    logic signed [DW-1:0] res_value_reg;
    logic signed [DW-1:0] res_value_next;
    logic [1:0]           res_status_reg;
    logic [1:0]           res_status_next;
    logic [CW-1:0]        res_count_reg;
    logic                 res_empty_reg;

    logic                 full;
    logic                 empty;
    logic [CW+OW-1:0]     count_wide;

    assign full  = valid_reg[CAP-1];
    assign empty = !valid_reg[0];

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            keep[i] = valid_reg[i] && (entries_reg[i] >= op_value_reg);
        end

        entries_next    = entries_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        res_value_next  = '0;
        res_status_next = mpq_pkg::ST_OK;

        if (op_cmd_reg == mpq_pkg::CMD_INSERT)
        begin
            if (full)
            begin
                res_status_next = mpq_pkg::ST_FULL;
            end
            else
            begin
                // Each cell keeps its value, takes the new one, or takes its
                // upper neighbour, so the new value lands behind its equals.
                for (int i = 0; i < CAP; i++)
                begin
                    if (keep[i])
                    begin
                        entries_next[i] = entries_reg[i];
                    end
                    else if (i == 0)
                    begin
                        entries_next[i] = op_value_reg;
                    end
                    else if (keep[i-1])
                    begin
                        entries_next[i] = op_value_reg;
                    end
                    else
                    begin
                        entries_next[i] = entries_reg[i-1];
                    end
                end
                valid_next = {valid_reg[CAP-2:0], 1'b1};
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                res_status_next = mpq_pkg::ST_EMPTY;
            end
            else
            begin
                res_value_next = entries_reg[0];
                for (int i = 0; i < CAP - 1; i++)
                begin
                    entries_next[i] = entries_reg[i+1];
                end
                valid_next = {1'b0, valid_reg[CAP-1:1]};
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_cmd_reg   <= cmd;
            op_value_reg <= value;
        end
        if (ctl.exec)
        begin
            entries_reg    <= entries_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= count_next;
            res_empty_reg  <= !valid_next[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (ctl.exec)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    assign count_wide   = {{OW{1'b0}}, res_count_reg};
    assign result_value = res_value_reg;
    assign status       = res_status_reg;
    assign entry_count  = count_wide[OW-1:0];
    assign is_empty     = res_empty_reg;

endmodule

@@ rtl/core/max_priority_queue.sv @@
// A request word is captured in the operand registers when accepted; its result
// word is registered from the execute state, once the output register is free
// or being drained. The controller takes no new request until the current one
// retires; the sorted cell row completes any insert or remove in that state.
// Reset clears the controller, the cell valid bits and the count; the queue
// starts empty and the stored values themselves are not cleared.
module max_priority_queue (
    input  logic            clk,
    input  logic            rst_n,
    mpq_req_if.sink         req,
    mpq_rsp_if.source       rsp
);

    mpq_pkg::ctl_t ctl;

    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .ctl       (ctl)
    );

    mpq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (req.cmd),
        .value        (req.value),
        .result_value (rsp.result_value),
        .status       (rsp.status),
        .entry_count  (rsp.entry_count),
        .is_empty     (rsp.is_empty)
    );

endmodule

@@ rtl/core/mpq_checker.sv @@
module mpq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [mpq_pkg::DATA_W-1:0] result_value,
    input logic [1:0]                        status,
    input logic [mpq_pkg::OUT_CNT_W-1:0]     entry_count,
    input logic                              is_empty
);

    // A result word waiting for the sink stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response word withdrawn while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one is executing");

    // A remove from an empty queue returns zero and leaves it empty.
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == mpq_pkg::ST_EMPTY)
            |-> is_empty && (result_value == '0))
        else $error("empty remove reported wrongly");

    // A dropped insert happens only on a non-empty queue and returns zero.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == mpq_pkg::ST_FULL)
            |-> !is_empty && (result_value == '0))
        else $error("full insert reported wrongly");

    // The empty flag agrees with the count whenever the count is exact.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (mpq_pkg::CAPACITY > 127) || (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .status       (rsp.status),
    .entry_count  (rsp.entry_count),
    .is_empty     (rsp.is_empty)
);

@@ verif/tb.sv @@
module tb;

    typedef struct {
        logic signed [mpq_pkg::DATA_W-1:0] result_value;
        logic [1:0]                        status;
        logic [mpq_pkg::OUT_CNT_W-1:0]     entry_count;
        logic                              is_empty;
    } answer_t;

    // Keeps its own sorted copy of the queue and the answers still owed by the block.
    class pq_mirror;
        logic signed [mpq_pkg::DATA_W-1:0] sorted_vals [mpq_pkg::CAPACITY];
        int unsigned                       held;
        answer_t                           pending [$];
        int unsigned                       mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void note_request(logic cmd, logic signed [mpq_pkg::DATA_W-1:0] value);
            answer_t want;
            int      pos;
            int      k;
            want.result_value = '0;
            want.status = mpq_pkg::ST_OK;
            if (cmd == mpq_pkg::CMD_INSERT)
            begin
                if (held >= mpq_pkg::CAPACITY)
                begin
                    want.status = mpq_pkg::ST_FULL;
                end
                else
                begin
                    // A new value goes behind every stored value equal to it.
                    pos = 0;
                    while (pos < held && sorted_vals[pos] >= value)
                        pos++;
                    for (k = held; k > pos; k--)
                        sorted_vals[k] = sorted_vals[k-1];
                    sorted_vals[pos] = value;
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    want.status = mpq_pkg::ST_EMPTY;
                end
                else
                begin
                    want.result_value = sorted_vals[0];
                    for (k = 0; k + 1 < held; k++)
                        sorted_vals[k] = sorted_vals[k+1];
                    held--;
                end
            end
            want.entry_count = held[mpq_pkg::OUT_CNT_W-1:0];
            want.is_empty = (held == 0);
            pending.push_back(want);
        endfunction

        function void check_answer(logic signed [mpq_pkg::DATA_W-1:0] rv, logic [1:0] st,
                                   logic [mpq_pkg::OUT_CNT_W-1:0] cnt, logic emp);
            answer_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word: value %0d status %0d count %0d empty %0b",
                         $time, rv, st, cnt, emp);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (rv !== want.result_value)
            begin
                $display("%0t: result_value expected %0d actual %0d",
                         $time, want.result_value, rv);
                mismatches++;
            end
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                mismatches++;
            end
            if (cnt !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, cnt);
                mismatches++;
            end
            if (emp !== want.is_empty)
            begin
                $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty, emp);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mpq_req_if req_if ();
    mpq_rsp_if rsp_if ();

    max_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    pq_mirror mirror = new();

    int req_idle_pct  = 25;
    int rsp_idle_pct  = 70;
    int rsp_hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                rsp_hold_left--;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready)
            mirror.check_answer(rsp_if.result_value, rsp_if.status,
                                rsp_if.entry_count, rsp_if.is_empty);
    end

    task automatic send_word(logic cmd, logic signed [mpq_pkg::DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd   <= cmd;
        req_if.value <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        mirror.note_request(cmd, value);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (mirror.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [mpq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel <= 4)
            return $urandom;
        else if (sel <= 7)
            return int'($urandom_range(8)) - 4;
        else if (sel == 8)
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else
            return $urandom_range(15);
    endfunction

    // Runs of mostly inserts, mostly removes or a mix push the queue to full and to empty.
    task automatic random_phase(int items);
        int   sent;
        int   run_len;
        int   insert_pct;
        logic cmd;
        sent = 0;
        while (sent < items)
        begin
            run_len = $urandom_range(120, 20);
            if (run_len > items - sent)
                run_len = items - sent;
            case ($urandom_range(2))
                0:       insert_pct = 90;
                1:       insert_pct = 10;
                default: insert_pct = 55;
            endcase
            repeat (run_len)
            begin
                cmd = ($urandom_range(99) < insert_pct) ? mpq_pkg::CMD_INSERT
                                                        : mpq_pkg::CMD_REMOVE;
                send_word(cmd, pick_value());
                sent++;
            end
        end
    endtask

    initial
    begin
        req_if.valid = 1'b0;
        req_if.cmd   = mpq_pkg::CMD_INSERT;
        req_if.value = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: remove from empty, extremes, equal values, drain to empty again.
        send_word(mpq_pkg::CMD_REMOVE, 32'sh1234_5678);
        send_word(mpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
        send_word(mpq_pkg::CMD_INSERT, 32'sh8000_0000);
        send_word(mpq_pkg::CMD_INSERT, 32'sh0000_0000);
        send_word(mpq_pkg::CMD_INSERT, -32'sd1);
        send_word(mpq_pkg::CMD_INSERT, 32'sd1);
        send_word(mpq_pkg::CMD_INSERT, 32'sd5);
        send_word(mpq_pkg::CMD_INSERT, 32'sd5);
        send_word(mpq_pkg::CMD_INSERT, -32'sd1);
        repeat (8)
            send_word(mpq_pkg::CMD_REMOVE, $urandom);
        send_word(mpq_pkg::CMD_REMOVE, 32'shFFFF_FFFF);
        send_word(mpq_pkg::CMD_INSERT, 32'sh8000_0000);
        send_word(mpq_pkg::CMD_REMOVE, 32'sh0000_0000);
        wait_for_drain();

        req_idle_pct = 25;
        rsp_idle_pct = 70;
        rsp_hold_left = 400;
        random_phase(640);
        wait_for_drain();

        req_idle_pct = 70;
        rsp_idle_pct = 25;
        random_phase(640);
        wait_for_drain();

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        rsp_hold_left = 300;
        random_phase(650);
        wait_for_drain();

        repeat (8) @(posedge clk);
        if (mirror.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
